// ===== hw/rtl/msrd_pkg.sv =====
`timescale 1ns / 1ps

package msrd_pkg;

   // framing bytes
   localparam logic [7:0] FLAG_BYTE  = 8'h7E;
   localparam logic [7:0] ESC_BYTE   = 8'h7D;
   localparam logic [7:0] ESC_XOR    = 8'h20;
   localparam logic [7:0] MIN_LENGTH = 8'd5;

   // crc-16 (reflected 0x1021), no final complement
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h8408;

   // default queue depths
   localparam int ITEM_QUEUE_DEPTH   = 4;
   localparam int RESULT_QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_ACCEPT  = 2'd1,
      KIND_REJECT  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      WHY_NONE  = 3'd0,
      WHY_FCS   = 3'd1,
      WHY_SHORT = 3'd2,
      WHY_NOEND = 3'd3,
      WHY_ESC   = 3'd4,
      WHY_FLAG  = 3'd5
   } reason_type;

   // classified line byte, front to back
   typedef struct packed {
      logic [7:0] data;
      logic       is_flag;
      logic       is_esc;
      logic       is_esc_ok;
   } item_type;

   // one result, back to result queue
   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload;
      reason_type reason;
      logic [7:0] length;
   } result_type;

   // one byte through the fcs, lsb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/msrd_fifo.sv =====
`timescale 1ns / 1ps

module msrd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = msrd_pkg::ITEM_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== hw/rtl/msrd_front.sv =====
`timescale 1ns / 1ps

module msrd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_rx_byte,
   output logic               item_push,
   input  logic               item_full,
   output msrd_pkg::item_type item
);

   logic               valid_ff, valid_in;
   msrd_pkg::item_type item_ff, item_in;
   logic               accept;

   // stage holds while the item queue is full
   assign req_full  = valid_ff && item_full;
   assign accept    = req_push && !req_full;
   assign item_push = valid_ff;
   assign item      = item_ff;

   // classify the line byte
   always_comb begin
      item_in.data      = req_rx_byte;
      item_in.is_flag   = (req_rx_byte == msrd_pkg::FLAG_BYTE);
      item_in.is_esc    = (req_rx_byte == msrd_pkg::ESC_BYTE);
      item_in.is_esc_ok = (req_rx_byte == (msrd_pkg::ESC_BYTE ^ msrd_pkg::ESC_XOR)) ||
                          (req_rx_byte == (msrd_pkg::FLAG_BYTE ^ msrd_pkg::ESC_XOR));
      valid_in          = accept || (valid_ff && item_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== hw/rtl/msrd_back.sv =====
`timescale 1ns / 1ps

module msrd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  msrd_pkg::item_type   item,
   output logic                 item_pop,
   input  logic                 result_full,
   output logic                 result_push,
   output msrd_pkg::result_type result
);

   typedef enum logic [2:0] {
      PH_WAIT = 3'd0,
      PH_VER  = 3'd1,
      PH_LEN  = 3'd2,
      PH_BODY = 3'd3,
      PH_ESC  = 3'd4,
      PH_FCSH = 3'd5,
      PH_FCSL = 3'd6,
      PH_END  = 3'd7
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] fcs_ff, fcs_in;
   logic [7:0]  length_ff, length_in;
   logic        take;
   logic        emit;
   logic [7:0]  body_byte;
   logic [7:0]  left_dec;

   // one item a cycle while the result queue has room
   assign take        = item_valid && !result_full;
   assign item_pop    = take;
   assign result_push = take && emit;

   assign body_byte = (phase_ff == PH_ESC) ? (item.data ^ msrd_pkg::ESC_XOR) : item.data;
   assign left_dec  = bytes_left_ff - 8'd1;

   // frame state machine
   always_comb begin
      phase_in       = phase_ff;
      bytes_left_in  = bytes_left_ff;
      crc_in         = crc_ff;
      fcs_in         = fcs_ff;
      length_in      = length_ff;
      emit           = 1'b0;
      result.kind    = msrd_pkg::KIND_PAYLOAD;
      result.payload = 8'h00;
      result.reason  = msrd_pkg::WHY_NONE;
      result.length  = length_ff;
      unique case (phase_ff)
         PH_WAIT: begin
            if (item.is_flag) begin
               phase_in      = PH_VER;
               crc_in        = msrd_pkg::CRC_INIT;
               bytes_left_in = 8'h00;
               fcs_in        = 16'h0000;
            end
         end
         PH_VER: begin
            crc_in   = msrd_pkg::crc_byte(crc_ff, item.data);
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            length_in     = item.data;
            result.length = item.data;
            if (item.data < msrd_pkg::MIN_LENGTH) begin
               phase_in      = PH_WAIT;
               emit          = 1'b1;
               result.kind   = msrd_pkg::KIND_REJECT;
               result.reason = msrd_pkg::WHY_SHORT;
            end else begin
               crc_in        = msrd_pkg::crc_byte(crc_ff, item.data);
               bytes_left_in = item.data;
               phase_in      = PH_BODY;
            end
         end
         PH_BODY, PH_ESC: begin
            if (phase_ff == PH_BODY && item.is_esc) begin
               phase_in = PH_ESC;
            end else if (item.is_flag) begin
               // flag inside body restarts the frame
               phase_in      = PH_VER;
               crc_in        = msrd_pkg::CRC_INIT;
               bytes_left_in = 8'h00;
               fcs_in        = 16'h0000;
               emit          = 1'b1;
               result.kind   = msrd_pkg::KIND_REJECT;
               result.reason = msrd_pkg::WHY_FLAG;
            end else if (phase_ff == PH_ESC && !item.is_esc_ok) begin
               phase_in      = PH_WAIT;
               emit          = 1'b1;
               result.kind   = msrd_pkg::KIND_REJECT;
               result.reason = msrd_pkg::WHY_ESC;
            end else begin
               crc_in         = msrd_pkg::crc_byte(crc_ff, body_byte);
               bytes_left_in  = left_dec;
               phase_in       = (left_dec == 8'h00) ? PH_FCSH : PH_BODY;
               emit           = 1'b1;
               result.payload = body_byte;
               result.length  = 8'h00;
            end
         end
         PH_FCSH: begin
            fcs_in   = {item.data, 8'h00};
            phase_in = PH_FCSL;
         end
         PH_FCSL: begin
            fcs_in   = {fcs_ff[15:8], item.data};
            phase_in = PH_END;
         end
         PH_END: begin
            phase_in = PH_WAIT;
            emit     = 1'b1;
            if (!item.is_flag) begin
               result.kind   = msrd_pkg::KIND_REJECT;
               result.reason = msrd_pkg::WHY_NOEND;
            end else if (fcs_ff != crc_ff) begin
               result.kind   = msrd_pkg::KIND_REJECT;
               result.reason = msrd_pkg::WHY_FCS;
            end else begin
               result.kind   = msrd_pkg::KIND_ACCEPT;
            end
         end
         default: begin
            phase_in = PH_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAIT;
         bytes_left_ff <= 8'h00;
         crc_ff        <= msrd_pkg::CRC_INIT;
         fcs_ff        <= 16'h0000;
         length_ff     <= 8'h00;
      end else if (take) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         crc_ff        <= crc_in;
         fcs_ff        <= fcs_in;
         length_ff     <= length_in;
      end
   end

endmodule

// ===== hw/rtl/mctp_serial_rx_deframer_top.sv =====
`timescale 1ns / 1ps
// path: a byte's result reaches the rsp ports via the front stage register, the item queue and the result queue
// throughput: one byte per cycle while the result queue has room, set by the one-byte crc step in the back end
// queue between front and back and the result queue keep each side stalling alone
// reset: synchronous active high, empties both queues and returns to flag hunt

module mctp_serial_rx_deframer_top #(
   parameter int ITEM_DEPTH   = msrd_pkg::ITEM_QUEUE_DEPTH,
   parameter int RESULT_DEPTH = msrd_pkg::RESULT_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_payload_byte,
   output logic [2:0] rsp_reject_reason,
   output logic [7:0] rsp_frame_length
);

   localparam int ITEM_W   = $bits(msrd_pkg::item_type);
   localparam int RESULT_W = $bits(msrd_pkg::result_type);

   msrd_pkg::item_type   front_item, back_item;
   msrd_pkg::result_type back_result, head_result;
   logic                 item_push, item_full, item_pop, item_empty;
   logic                 result_push, result_full;
   logic [ITEM_W-1:0]    item_rdata;
   logic [RESULT_W-1:0]  result_rdata;

   // input stage and classifier
   msrd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_rx_byte (req_rx_byte),
      .item_push   (item_push),
      .item_full   (item_full),
      .item        (front_item)
   );

   // queue between front and back
   msrd_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (ITEM_DEPTH)
   ) u_item_queue (
      .clock (clock),
      .reset (reset),
      .push  (item_push),
      .full  (item_full),
      .wdata (front_item),
      .pop   (item_pop),
      .empty (item_empty),
      .rdata (item_rdata)
   );

   assign back_item = msrd_pkg::item_type'(item_rdata);

   // frame state machine and crc
   msrd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (!item_empty),
      .item        (back_item),
      .item_pop    (item_pop),
      .result_full (result_full),
      .result_push (result_push),
      .result      (back_result)
   );

   // result queue
   msrd_fifo #(
      .WIDTH (RESULT_W),
      .DEPTH (RESULT_DEPTH)
   ) u_result_queue (
      .clock (clock),
      .reset (reset),
      .push  (result_push),
      .full  (result_full),
      .wdata (back_result),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (result_rdata)
   );

   assign head_result       = msrd_pkg::result_type'(result_rdata);
   assign rsp_out_kind      = head_result.kind;
   assign rsp_payload_byte  = head_result.payload;
   assign rsp_reject_reason = head_result.reason;
   assign rsp_frame_length  = head_result.length;

endmodule
